@@ sv/lap_timer_controller_core_assert.svh @@
// ----------------------------------------------------------------------------
// Lap timer controller assertion macros
// Concurrent check macros, clocked on clk and held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef LAP_TIMER_CONTROLLER_CORE_ASSERT_SVH
`define LAP_TIMER_CONTROLLER_CORE_ASSERT_SVH

`ifndef SYNTH

// condition that must hold at every clock edge
`define LTC_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("lap timer check failed");

// consequent that must hold in the same cycle as the antecedent
`define LTC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lap timer check failed");

// consequent that must hold in the cycle after the antecedent
`define LTC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lap timer check failed");

`else

`define LTC_ASSERT_ALWAYS(label, cond)
`define LTC_ASSERT_IMPL(label, ante, cons)
`define LTC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ sv/ltc_pkg.sv @@
// ----------------------------------------------------------------------------
// Lap timer controller package
// Command codes, field widths, display constants and reset values
// ----------------------------------------------------------------------------
`default_nettype none

package ltc_pkg;

	// field widths
	localparam int CMD_W    = 3;
	localparam int LEVEL_W  = 7;
	localparam int VALUE_W  = 12;
	localparam int DOT_W    = 2;
	localparam int LAPS_W   = 8;
	localparam int SEC_W    = 8;
	localparam int TENTH_W  = 4;
	localparam int MSSUB_W  = 7;

	// stream packing
	localparam int S_TDATA_W = 8;
	localparam int S_TUSER_W = CMD_W;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 1;

	// elapsed counter width
	localparam int ELAPSED_BITS_DEF = 32;

	// command codes
	localparam logic [CMD_W-1:0] CMD_MODE    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READY   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RESET   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SENSOR  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_BATTERY = 3'd4;
	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd6;

	// configuration register indexes
	localparam logic CFG_AUTO_MODE   = 1'b0;
	localparam logic CFG_TARGET_LAPS = 1'b1;

	// result kinds and decimal point positions
	localparam logic             KIND_BEEP    = 1'b0;
	localparam logic             KIND_DISPLAY = 1'b1;
	localparam logic [DOT_W-1:0] DOT_NONE     = 2'd0;
	localparam logic [DOT_W-1:0] DOT_TIME     = 2'd3;

	// time base: 100 ms per tenth, 10 tenths per second
	localparam int MS_PER_TENTH   = 100;
	localparam int TENTHS_PER_SEC = 10;

	// reset values
	localparam logic [LAPS_W-1:0]  TARGET_LAPS_RST = 8'd10;
	localparam logic [LEVEL_W-1:0] BATTERY_RST     = 7'd100;

endpackage

`default_nettype wire

@@ sv/lap_timer_controller_core.sv @@
// ----------------------------------------------------------------------------
// Lap timer controller core
// Phase control, lap counting, millisecond time base and display values
// ----------------------------------------------------------------------------
// Items arrive on the s_axis channel: tuser carries the command, tdata the
// battery level. Key presses, sensor triggers, battery updates and ms ticks
// only change state; a refresh gives a display item, and an accepted sensor
// trigger in auto mode gives a beep item, both on the m_axis channel.
// Each item is taken into an input register and handled once the output
// register is free, its result landing in the output register; one item
// per cycle is sustained while the receiver does not stall.
// The time base is kept as seconds (mod 256), tenths and milliseconds
// alongside the binary elapsed counter, so no divider sits in the path.
// When the receiver stalls, the output register holds its item and the
// input register still takes a new one while the output slot is busy;
// s_axis_tready drops only once both are full.
// The configuration port writes auto_mode (index 0) and target_laps
// (index 1); write it only while the core is idle.
// Reset clears the phase, lap count and timers, selects battery display,
// sets the battery to 100 percent, manual mode and a target of ten laps.
// ----------------------------------------------------------------------------
`default_nettype none

module lap_timer_controller_core
	import ltc_pkg::*;
#(
	parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input items
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // [6:0] battery_level, [7] zero
	input  wire logic [S_TUSER_W-1:0] s_axis_tuser,  // [2:0] cmd
	// result items
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0]      m_axis_tdata,  // [11:0] display_value,
	                                                 // [13:12] dot_position, [15:14] zero
	output logic [M_TUSER_W-1:0]      m_axis_tuser,  // [0] result_kind
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [LAPS_W-1:0]    cfg_data
);

	typedef enum logic [1:0] {
		PH_READY  = 2'd0,
		PH_TIMING = 2'd1,
		PH_FINISH = 2'd2
	} phase_t;

	// configuration registers
	logic              auto_mode_q;
	logic [LAPS_W-1:0] target_laps_q;

	// input register
	logic               valid_s1;
	logic [CMD_W-1:0]   cmd_s1;
	logic [LEVEL_W-1:0] level_s1;

	// state
	phase_t              phase_q,     phase_d;
	logic                show_time_q, show_time_d;
	logic [LAPS_W-1:0]   lap_q,       lap_d;
	logic [ELAPSED_BITS-1:0] elapsed_q, elapsed_d;
	logic [MSSUB_W-1:0]  ms_sub_q,    ms_sub_d;
	logic [TENTH_W-1:0]  tenth_q,     tenth_d;
	logic [SEC_W-1:0]    sec_q,       sec_d;
	logic [TENTH_W-1:0]  fin_tenth_q, fin_tenth_d;
	logic [SEC_W-1:0]    fin_sec_q,   fin_sec_d;
	logic [LEVEL_W-1:0]  battery_q,   battery_d;

	// result register
	logic               out_valid_q;
	logic               out_kind_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [DOT_W-1:0]   out_dot_q;

	logic               out_free;
	logic               fire_s1;
	logic               res_valid;
	logic               res_kind;
	logic [VALUE_W-1:0] res_value;
	logic [DOT_W-1:0]   res_dot;
	logic [LAPS_W-1:0]  lap_inc;
	logic [SEC_W-1:0]   show_sec;
	logic [TENTH_W-1:0] show_tenth;

	// handshake
	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire_s1       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {{(M_TDATA_W - VALUE_W - DOT_W){1'b0}}, out_dot_q, out_value_q};

	assign lap_inc = lap_q + LAPS_W'(1);

	// time shown on a refresh
	always_comb begin
		show_sec   = '0;
		show_tenth = '0;
		if (phase_q == PH_TIMING) begin
			show_sec   = sec_q;
			show_tenth = tenth_q;
		end else if (phase_q == PH_FINISH) begin
			show_sec   = fin_sec_q;
			show_tenth = fin_tenth_q;
		end
	end

	// command decode, next state and result
	always_comb begin
		phase_d     = phase_q;
		show_time_d = show_time_q;
		lap_d       = lap_q;
		elapsed_d   = elapsed_q;
		ms_sub_d    = ms_sub_q;
		tenth_d     = tenth_q;
		sec_d       = sec_q;
		fin_tenth_d = fin_tenth_q;
		fin_sec_d   = fin_sec_q;
		battery_d   = battery_q;
		res_valid   = 1'b0;
		res_kind    = KIND_BEEP;
		res_value   = '0;
		res_dot     = DOT_NONE;
		unique case (cmd_s1)
			CMD_MODE: begin
				show_time_d = !show_time_q;
			end
			CMD_READY: begin
				if (phase_q == PH_TIMING) phase_d = PH_READY;
			end
			CMD_RESET: begin
				if (auto_mode_q || phase_q == PH_FINISH) begin
					phase_d     = PH_READY;
					lap_d       = '0;
					fin_sec_d   = '0;
					fin_tenth_d = '0;
				end else if (phase_q == PH_READY) begin
					phase_d   = PH_TIMING;
					elapsed_d = '0;
					ms_sub_d  = '0;
					tenth_d   = '0;
					sec_d     = '0;
				end else if (phase_q == PH_TIMING) begin
					phase_d     = PH_FINISH;
					fin_sec_d   = sec_q;
					fin_tenth_d = tenth_q;
				end
			end
			CMD_SENSOR: begin
				if (show_time_q && auto_mode_q) begin
					if (phase_q == PH_READY) begin
						phase_d   = PH_TIMING;
						elapsed_d = '0;
						ms_sub_d  = '0;
						tenth_d   = '0;
						sec_d     = '0;
						res_valid = 1'b1;
					end else if (phase_q == PH_TIMING) begin
						lap_d     = lap_inc;
						res_valid = 1'b1;
						if (lap_inc >= target_laps_q) begin
							phase_d     = PH_FINISH;
							fin_sec_d   = sec_q;
							fin_tenth_d = tenth_q;
						end
					end
				end
			end
			CMD_BATTERY: begin
				battery_d = level_s1;
			end
			CMD_TICK: begin
				// the decimal time base restarts with the binary counter on wrap
				if (elapsed_q == '1) begin
					elapsed_d = '0;
					ms_sub_d  = '0;
					tenth_d   = '0;
					sec_d     = '0;
				end else begin
					elapsed_d = elapsed_q + ELAPSED_BITS'(1);
					if (ms_sub_q == MSSUB_W'(MS_PER_TENTH - 1)) begin
						ms_sub_d = '0;
						if (tenth_q == TENTH_W'(TENTHS_PER_SEC - 1)) begin
							tenth_d = '0;
							sec_d   = sec_q + SEC_W'(1);
						end else begin
							tenth_d = tenth_q + TENTH_W'(1);
						end
					end else begin
						ms_sub_d = ms_sub_q + MSSUB_W'(1);
					end
				end
			end
			CMD_REFRESH: begin
				res_valid = 1'b1;
				res_kind  = KIND_DISPLAY;
				if (!show_time_q) begin
					res_value = VALUE_W'(battery_q);
				end else begin
					// seconds * 10 + tenths, as shifts and adds
					res_value = {1'b0, show_sec, 3'b000} + {3'b000, show_sec, 1'b0}
						+ VALUE_W'(show_tenth);
					res_dot   = DOT_TIME;
				end
			end
			default: begin
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_mode_q   <= 1'b0;
			target_laps_q <= TARGET_LAPS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AUTO_MODE:   auto_mode_q   <= cfg_data[0];
				CFG_TARGET_LAPS: target_laps_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// control state and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_READY;
			show_time_q <= 1'b0;
			lap_q       <= '0;
			elapsed_q   <= '0;
			ms_sub_q    <= '0;
			tenth_q     <= '0;
			sec_q       <= '0;
			fin_tenth_q <= '0;
			fin_sec_q   <= '0;
			battery_q   <= BATTERY_RST;
		end else begin
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
			if (out_free) out_valid_q <= fire_s1 && res_valid;
			if (fire_s1) begin
				phase_q     <= phase_d;
				show_time_q <= show_time_d;
				lap_q       <= lap_d;
				elapsed_q   <= elapsed_d;
				ms_sub_q    <= ms_sub_d;
				tenth_q     <= tenth_d;
				sec_q       <= sec_d;
				fin_tenth_q <= fin_tenth_d;
				fin_sec_q   <= fin_sec_d;
				battery_q   <= battery_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1   <= s_axis_tuser;
			level_s1 <= s_axis_tdata[LEVEL_W-1:0];
		end
		if (fire_s1 && res_valid) begin
			out_kind_q  <= res_kind;
			out_value_q <= res_value;
			out_dot_q   <= res_dot;
		end
	end

	// checks
`include "lap_timer_controller_core_assert.svh"

	`LTC_ASSERT_ALWAYS(a_time_base_range,
		ms_sub_q <= MSSUB_W'(MS_PER_TENTH - 1) && tenth_q <= TENTH_W'(TENTHS_PER_SEC - 1))
	`LTC_ASSERT_IMPL(a_beep_is_blank, out_valid_q && out_kind_q == KIND_BEEP,
		out_value_q == '0 && out_dot_q == DOT_NONE)
	`LTC_ASSERT_NEXT(a_start_clears_time,
		fire_s1 && phase_q == PH_READY && phase_d == PH_TIMING,
		elapsed_q == '0 && sec_q == '0 && tenth_q == '0)

endmodule

`default_nettype wire
